@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL of the serial GPIO interrupt controller.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is high.
`define SGIC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same-cycle implication, disabled while reset is high.
`define SGIC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ hdl/sgic_pkg.sv @@
// Package for the serial GPIO interrupt controller: sizes, address map,
// control word layout, codes, transfer structs and the pair index decode.
// Depends on nothing.
package sgic_pkg;

   // Sizes and address map.
   localparam int PIN_PAIRS    = 256;
   localparam int STATUS_WORDS = 8;
   localparam int STATUS_BASE  = 0;
   localparam int CONTROL_BASE = 256;

   localparam int WORD_W    = 32;
   localparam int ADDR_W    = 10;
   localparam int ADDR_X_W  = ADDR_W + 1;
   localparam int PIN_W     = 9;
   localparam int PAIR_W    = 8;
   localparam int PAIR_X_W  = PAIR_W + 1;
   localparam int BIT_IDX_W = 5;
   localparam int STS_IDX_W = PAIR_W - BIT_IDX_W;
   localparam int STS_X_W   = STS_IDX_W + 1;
   localparam int CNT_W     = 9;

   // Function codes of an input transfer.
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_PIN   = 2'd2;

   // Control word layout.
   localparam int CW_IN_BIT   = 0;
   localparam int CW_OUT_BIT  = 1;
   localparam int CW_EN_BIT   = 2;
   localparam int CW_TYPE_LSB = 3;
   localparam int CW_TYPE_MSB = 5;
   localparam int CW_CLR_BIT  = 6;

   // Trigger types; every code from four up means dual edge.
   localparam logic [2:0] TRIG_FALL = 3'd0;
   localparam logic [2:0] TRIG_RISE = 3'd1;
   localparam logic [2:0] TRIG_LOW  = 3'd2;
   localparam logic [2:0] TRIG_HIGH = 3'd3;

   typedef struct packed {
      logic [1:0]        func;
      logic [ADDR_W-1:0] reg_addr;
      logic [WORD_W-1:0] write_data;
      logic [PIN_W-1:0]  pin_number;
      logic              pin_level;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              irq_line;
      logic              out_changed;
      logic [PAIR_W-1:0] out_change_pair;
   } rsp_type;

   // State update produced for one item.
   typedef struct packed {
      logic                 ctl_we;
      logic [WORD_W-1:0]    ctl_wdata;
      logic                 sts_we;
      logic [STS_IDX_W-1:0] sts_idx;
      logic [WORD_W-1:0]    sts_wdata;
      logic [CNT_W-1:0]     cnt;
   } upd_type;

   // Pin pair that an item addresses: from the pin for a level change,
   // otherwise from the offset into the control window.
   function automatic logic [PAIR_W-1:0] pair_index(req_type r);
      logic [ADDR_W-1:0] c_off;
      c_off = r.reg_addr - ADDR_W'(CONTROL_BASE);
      if (r.func == FUNC_PIN) begin
         return r.pin_number[PIN_W-1:1];
      end
      return c_off[PAIR_W-1:0];
   endfunction

endpackage

@@ hdl/sgic_eval.sv @@
// Item evaluation for the serial GPIO interrupt controller: address decode,
// control word update, trigger check, status and pending count update.
// Depends on sgic_pkg.
module sgic_eval (
   input  sgic_pkg::req_type                                      item,
   input  logic [sgic_pkg::WORD_W-1:0]                            cw_cur,
   input  logic [sgic_pkg::STATUS_WORDS-1:0][sgic_pkg::WORD_W-1:0] sts_cur,
   input  logic [sgic_pkg::CNT_W-1:0]                             cnt_cur,
   output sgic_pkg::upd_type                                      upd,
   output sgic_pkg::rsp_type                                      rsp
);

   logic [sgic_pkg::PAIR_W-1:0]    pair;
   logic                           s_hit;
   logic                           c_hit;
   logic                           pair_ok;
   logic [sgic_pkg::ADDR_W-1:0]    s_off;
   logic [sgic_pkg::STS_IDX_W-1:0] sts_idx;
   logic                           sts_ok;
   logic [sgic_pkg::WORD_W-1:0]    sts_word;
   logic [sgic_pkg::BIT_IDX_W-1:0] bpos;
   logic                           tgt;
   logic [sgic_pkg::WORD_W-1:0]    nw;
   logic [sgic_pkg::WORD_W-1:0]    diff;
   logic [sgic_pkg::WORD_W-1:0]    stored;
   logic                           upd_en;
   logic                           rise;
   logic                           fall;
   logic                           hit;
   logic                           set_en;
   logic [2:0]                     kind;
   logic                           bit_old;
   logic                           bit_new;
   logic [sgic_pkg::WORD_W-1:0]    sts_new;
   logic [sgic_pkg::CNT_W-1:0]     cnt_next;

   // Address decode; the status window wins where the two overlap.
   assign pair  = sgic_pkg::pair_index(item);
   assign s_hit = (item.reg_addr >= sgic_pkg::ADDR_W'(sgic_pkg::STATUS_BASE)) &&
                  ({1'b0, item.reg_addr} <
                   sgic_pkg::ADDR_X_W'(sgic_pkg::STATUS_BASE + sgic_pkg::STATUS_WORDS));
   assign c_hit = (item.reg_addr >= sgic_pkg::ADDR_W'(sgic_pkg::CONTROL_BASE)) &&
                  ({1'b0, item.reg_addr} <
                   sgic_pkg::ADDR_X_W'(sgic_pkg::CONTROL_BASE + sgic_pkg::PIN_PAIRS));
   assign pair_ok = {1'b0, pair} < sgic_pkg::PAIR_X_W'(sgic_pkg::PIN_PAIRS);

   // One status word is touched per item: the addressed one for a read,
   // the pair's own word otherwise.
   assign s_off   = item.reg_addr - sgic_pkg::ADDR_W'(sgic_pkg::STATUS_BASE);
   assign sts_idx = (item.func == sgic_pkg::FUNC_READ) ? s_off[sgic_pkg::STS_IDX_W-1:0] :
                    pair[sgic_pkg::PAIR_W-1 -: sgic_pkg::STS_IDX_W];
   assign sts_ok  = {1'b0, sts_idx} < sgic_pkg::STS_X_W'(sgic_pkg::STATUS_WORDS);
   assign sts_word = sts_ok ? sts_cur[sts_idx] : '0;
   assign bpos     = pair[sgic_pkg::BIT_IDX_W-1:0];

   // New control word from a bus write or a pin level change.
   always_comb begin
      nw = cw_cur;
      if (item.func == sgic_pkg::FUNC_WRITE) begin
         nw = item.write_data;
      end else if (item.pin_number[0]) begin
         nw[sgic_pkg::CW_OUT_BIT] = item.pin_level;
      end else begin
         nw[sgic_pkg::CW_IN_BIT] = item.pin_level;
      end
   end

   assign tgt = ((item.func == sgic_pkg::FUNC_WRITE) && !s_hit && c_hit) ||
                ((item.func == sgic_pkg::FUNC_PIN) && pair_ok);
   assign diff   = cw_cur ^ nw;
   assign upd_en = tgt && (diff != '0);

   // The status clear bit acts once and is never stored.
   always_comb begin
      stored = nw;
      stored[sgic_pkg::CW_CLR_BIT] = 1'b0;
   end

   // Trigger check on a change of the input value.
   assign rise = stored[sgic_pkg::CW_IN_BIT] && !cw_cur[sgic_pkg::CW_IN_BIT];
   assign fall = !stored[sgic_pkg::CW_IN_BIT] && cw_cur[sgic_pkg::CW_IN_BIT];
   assign kind = stored[sgic_pkg::CW_TYPE_MSB:sgic_pkg::CW_TYPE_LSB];

   always_comb begin
      case (kind)
         sgic_pkg::TRIG_FALL: hit = fall;
         sgic_pkg::TRIG_RISE: hit = rise;
         sgic_pkg::TRIG_LOW:  hit = !stored[sgic_pkg::CW_IN_BIT];
         sgic_pkg::TRIG_HIGH: hit = stored[sgic_pkg::CW_IN_BIT];
         default:             hit = rise || fall;
      endcase
   end

   assign set_en = upd_en && diff[sgic_pkg::CW_IN_BIT] && stored[sgic_pkg::CW_EN_BIT] && hit;

   // Status bit: clear first, then set; the count follows the bit's change.
   always_comb begin
      bit_old = sts_word[bpos];
      bit_new = bit_old;
      if (upd_en && nw[sgic_pkg::CW_CLR_BIT]) begin
         bit_new = 1'b0;
      end
      if (set_en) begin
         bit_new = 1'b1;
      end
      sts_new       = sts_word;
      sts_new[bpos] = bit_new;
      cnt_next      = cnt_cur;
      if (upd_en && sts_ok && bit_old && !bit_new) begin
         cnt_next = cnt_cur - sgic_pkg::CNT_W'(1);
      end else if (upd_en && sts_ok && !bit_old && bit_new) begin
         cnt_next = cnt_cur + sgic_pkg::CNT_W'(1);
      end
   end

   // State update.
   always_comb begin
      upd.ctl_we    = upd_en;
      upd.ctl_wdata = stored;
      upd.sts_we    = upd_en && sts_ok;
      upd.sts_idx   = sts_idx;
      upd.sts_wdata = sts_new;
      upd.cnt       = cnt_next;
   end

   // Result item.
   always_comb begin
      rsp.read_data = '0;
      if (item.func == sgic_pkg::FUNC_READ) begin
         if (s_hit) begin
            rsp.read_data = sts_word;
         end else if (c_hit) begin
            rsp.read_data = cw_cur;
         end
      end
      rsp.irq_line        = cnt_next != '0;
      rsp.out_changed     = upd_en && diff[sgic_pkg::CW_OUT_BIT];
      rsp.out_change_pair = rsp.out_changed ? pair : '0;
   end

endmodule

@@ hdl/serial_gpio_interrupt_controller.sv @@
// Top level of the serial GPIO interrupt controller: control word memory,
// status store, pending count, pipeline control and result register.
// Depends on sgic_pkg, sgic_eval and assert_macros.svh.
//
// Usage: each transfer on the req_ channel is a bus read, a bus write of a
// pin pair's control word, or a level change on one external pin. Every
// accepted item yields exactly one transfer on the rsp_ channel, in order,
// with the read data, the interrupt line after the item and the output
// change flag with its pair.
// An accepted item waits in the evaluation stage; its result is
// registered when that stage fires. Throughput: one item per cycle while
// no result is stalled, set by the read-modify-write of the control word
// memory, read at acceptance and written as the item leaves that stage,
// with a bypass of the last write for back-to-back items to the same pair.
// Reset: synchronous and active high; the status store and pending count
// clear and every control word reads zero at once through per-entry valid
// flags, so no clearing pass is needed and req_stall is low after reset.
// Stall: when rsp_stall holds a result, the item behind it waits in the
// evaluation stage and req_stall rises; no state changes while stalled.
`include "assert_macros.svh"

module serial_gpio_interrupt_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sgic_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sgic_pkg::rsp_type rsp_data
);

   // Control word memory and its per-entry valid flags.
   logic [sgic_pkg::WORD_W-1:0]    ctl_mem [sgic_pkg::PIN_PAIRS];
   logic [sgic_pkg::WORD_W-1:0]    ctl_rd_ff;
   logic [sgic_pkg::PIN_PAIRS-1:0] ctl_vld_ff;

   // Bypass of the most recent control word write.
   logic                        fwd_vld_ff;
   logic [sgic_pkg::PAIR_W-1:0] fwd_idx_ff;
   logic [sgic_pkg::WORD_W-1:0] fwd_data_ff;

   // Evaluation stage.
   logic                        b_vld_ff;
   logic                        b_vld_in;
   sgic_pkg::req_type           b_item_ff;
   logic [sgic_pkg::PAIR_W-1:0] b_idx_ff;
   logic [sgic_pkg::PAIR_W-1:0] a_idx;
   logic                        b_adv;
   logic                        b_fire;
   logic                        req_acc;
   logic [sgic_pkg::WORD_W-1:0] cw_cur;

   // Status store and pending count.
   logic [sgic_pkg::STATUS_WORDS-1:0][sgic_pkg::WORD_W-1:0] sts_ff;
   logic [sgic_pkg::CNT_W-1:0]                               cnt_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   sgic_pkg::rsp_type rsp_data_ff;

   sgic_pkg::upd_type upd;
   sgic_pkg::rsp_type rsp_next;

   // Handshake and stage control.
   assign b_adv     = !rsp_valid_ff || !rsp_stall;
   assign b_fire    = b_vld_ff && b_adv;
   assign req_stall = b_vld_ff && !b_adv;
   assign req_acc   = req_valid && !req_stall;
   assign b_vld_in  = req_acc || (b_vld_ff && !b_fire);
   assign a_idx     = sgic_pkg::pair_index(req_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         b_item_ff <= req_data;
         b_idx_ff  <= a_idx;
      end
   end

   // Memory: written by the evaluation stage, read at acceptance.
   always_ff @(posedge clock) begin
      if (b_fire && upd.ctl_we) begin
         ctl_mem[b_idx_ff] <= upd.ctl_wdata;
      end
      if (req_acc) begin
         ctl_rd_ff <= ctl_mem[a_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_vld_ff <= '0;
      end else if (b_fire && upd.ctl_we) begin
         ctl_vld_ff[b_idx_ff] <= 1'b1;
      end
   end

   // The memory read at acceptance misses a write made on the same edge.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else if (b_fire) begin
         fwd_vld_ff <= upd.ctl_we;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         fwd_idx_ff  <= b_idx_ff;
         fwd_data_ff <= upd.ctl_wdata;
      end
   end

   // Current control word of the item in the evaluation stage.
   assign cw_cur = (fwd_vld_ff && (fwd_idx_ff == b_idx_ff)) ? fwd_data_ff :
                   (ctl_vld_ff[b_idx_ff] ? ctl_rd_ff : '0);

   sgic_eval u_eval (
      .item    (b_item_ff),
      .cw_cur  (cw_cur),
      .sts_cur (sts_ff),
      .cnt_cur (cnt_ff),
      .upd     (upd),
      .rsp     (rsp_next)
   );

   // Status store and pending count update.
   always_ff @(posedge clock) begin
      if (reset) begin
         sts_ff <= '0;
         cnt_ff <= '0;
      end else if (b_fire) begin
         if (upd.sts_we) begin
            sts_ff[upd.sts_idx] <= upd.sts_wdata;
         end
         cnt_ff <= upd.cnt;
      end
   end

   // Result register.
   assign rsp_valid_in = b_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The held result's interrupt line agrees with the pending count.
   `SGIC_ASSERT_IMP(a_irq_tracks_count, rsp_valid_ff, rsp_data_ff.irq_line == (cnt_ff != '0), "irq line in result disagrees with pending count")
   // The pending count always equals the number of set status bits.
   `SGIC_ASSERT(a_count_matches_status, cnt_ff == sgic_pkg::CNT_W'($countones(sts_ff)), "pending count differs from status bits")
   // No state update happens while a result is held by the receiver.
   `SGIC_ASSERT(a_stall_freezes_state, rsp_valid_ff && rsp_stall |=> $stable(cnt_ff) && $stable(sts_ff), "state changed while result was stalled")

endmodule

@@ bench/tb_serial_gpio_interrupt_controller.sv @@
// Self-checking testbench for serial_gpio_interrupt_controller: directed and random bus
// reads, control word writes and pin level changes, checked against an in-bench model.
// Depends on sgic_pkg and the controller RTL.
module tb_serial_gpio_interrupt_controller;

   // Function code with no operation behind it.
   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int RANDOM_ITEMS = 1172;
   localparam int CALM_TAIL = 100;
   localparam int SETTLE_CYCLES = 10;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      sgic_pkg::req_type req;
      bit                drain_first;
   } stim_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sgic_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sgic_pkg::rsp_type rsp_data;

   // Model state of the controller.
   logic [sgic_pkg::WORD_W-1:0] ctl_words [sgic_pkg::PIN_PAIRS];
   logic [sgic_pkg::WORD_W-1:0] sts_words [sgic_pkg::STATUS_WORDS];
   logic [sgic_pkg::CNT_W-1:0]  set_bits;
   bit                          chg_out;
   logic [sgic_pkg::PAIR_W-1:0] chg_pair;

   stim_type          items_to_send [$];
   sgic_pkg::rsp_type responses_due [$];
   int                total_items;
   int                sent_count;
   int                rsp_seen;
   int                errors;
   int                idle_left;
   int                hold_left;
   int                idle_phase;
   int                hold_phase;

   serial_gpio_interrupt_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Apply a new control word to one pair: status clear, output change flag
   // and the trigger check on an input change.
   function automatic void update_word(int pair, logic [sgic_pkg::WORD_W-1:0] value);
      logic [sgic_pkg::WORD_W-1:0] prev_w;
      logic [sgic_pkg::WORD_W-1:0] new_w;
      logic [sgic_pkg::WORD_W-1:0] diff;
      logic [2:0]                  kind;
      logic                        rise;
      logic                        fall;
      logic                        hit;
      int                          w;
      int                          b;
      prev_w = ctl_words[pair];
      new_w = value;
      diff = prev_w ^ new_w;
      w = pair / sgic_pkg::WORD_W;
      b = pair % sgic_pkg::WORD_W;
      if (diff == '0) begin
         return;
      end
      if (new_w[sgic_pkg::CW_CLR_BIT]) begin
         if (w < sgic_pkg::STATUS_WORDS && sts_words[w][b]) begin
            sts_words[w][b] = 1'b0;
            set_bits = set_bits - sgic_pkg::CNT_W'(1);
         end
         new_w[sgic_pkg::CW_CLR_BIT] = 1'b0;
      end
      ctl_words[pair] = new_w;
      if (diff[sgic_pkg::CW_OUT_BIT]) begin
         chg_out = 1'b1;
         chg_pair = pair[sgic_pkg::PAIR_W-1:0];
      end
      if (diff[sgic_pkg::CW_IN_BIT] && new_w[sgic_pkg::CW_EN_BIT]) begin
         kind = new_w[sgic_pkg::CW_TYPE_MSB:sgic_pkg::CW_TYPE_LSB];
         rise = new_w[sgic_pkg::CW_IN_BIT] && !prev_w[sgic_pkg::CW_IN_BIT];
         fall = !new_w[sgic_pkg::CW_IN_BIT] && prev_w[sgic_pkg::CW_IN_BIT];
         case (kind)
            sgic_pkg::TRIG_FALL: hit = fall;
            sgic_pkg::TRIG_RISE: hit = rise;
            sgic_pkg::TRIG_LOW:  hit = !new_w[sgic_pkg::CW_IN_BIT];
            sgic_pkg::TRIG_HIGH: hit = new_w[sgic_pkg::CW_IN_BIT];
            default:             hit = rise || fall;
         endcase
         if (hit && w < sgic_pkg::STATUS_WORDS && !sts_words[w][b]) begin
            sts_words[w][b] = 1'b1;
            set_bits = set_bits + sgic_pkg::CNT_W'(1);
         end
      end
   endfunction

   // Advance the model by one item and return the response it owes.
   function automatic sgic_pkg::rsp_type next_response(sgic_pkg::req_type r);
      sgic_pkg::rsp_type           res;
      int                          sidx;
      int                          cidx;
      int                          pair;
      logic [sgic_pkg::WORD_W-1:0] v;
      res = '0;
      chg_out = 1'b0;
      chg_pair = '0;
      sidx = int'(r.reg_addr) - sgic_pkg::STATUS_BASE;
      cidx = int'(r.reg_addr) - sgic_pkg::CONTROL_BASE;
      case (r.func)
         sgic_pkg::FUNC_READ: begin
            if (sidx >= 0 && sidx < sgic_pkg::STATUS_WORDS) begin
               res.read_data = sts_words[sidx];
            end else if (cidx >= 0 && cidx < sgic_pkg::PIN_PAIRS) begin
               res.read_data = ctl_words[cidx];
            end
         end
         sgic_pkg::FUNC_WRITE: begin
            if (!(sidx >= 0 && sidx < sgic_pkg::STATUS_WORDS) &&
                cidx >= 0 && cidx < sgic_pkg::PIN_PAIRS) begin
               update_word(cidx, r.write_data);
            end
         end
         sgic_pkg::FUNC_PIN: begin
            pair = int'(r.pin_number) >> 1;
            if (pair < sgic_pkg::PIN_PAIRS) begin
               v = ctl_words[pair];
               if (r.pin_number[0]) begin
                  v[sgic_pkg::CW_OUT_BIT] = r.pin_level;
               end else begin
                  v[sgic_pkg::CW_IN_BIT] = r.pin_level;
               end
               update_word(pair, v);
            end
         end
         default: ;
      endcase
      res.irq_line = (set_bits != '0);
      res.out_changed = chg_out;
      res.out_change_pair = chg_out ? chg_pair : '0;
      return res;
   endfunction

   function automatic logic [sgic_pkg::WORD_W-1:0] ctl_word(bit en, logic [2:0] trig,
                                                             bit in_v, bit out_v, bit clr);
      logic [sgic_pkg::WORD_W-1:0] w;
      w = '0;
      w[sgic_pkg::CW_IN_BIT] = in_v;
      w[sgic_pkg::CW_OUT_BIT] = out_v;
      w[sgic_pkg::CW_EN_BIT] = en;
      w[sgic_pkg::CW_TYPE_MSB:sgic_pkg::CW_TYPE_LSB] = trig;
      w[sgic_pkg::CW_CLR_BIT] = clr;
      return w;
   endfunction

   function automatic sgic_pkg::req_type read_item(int addr);
      sgic_pkg::req_type r;
      r = '0;
      r.func = sgic_pkg::FUNC_READ;
      r.reg_addr = addr[sgic_pkg::ADDR_W-1:0];
      return r;
   endfunction

   function automatic sgic_pkg::req_type write_item(int addr,
                                                    logic [sgic_pkg::WORD_W-1:0] data);
      sgic_pkg::req_type r;
      r = '0;
      r.func = sgic_pkg::FUNC_WRITE;
      r.reg_addr = addr[sgic_pkg::ADDR_W-1:0];
      r.write_data = data;
      return r;
   endfunction

   function automatic sgic_pkg::req_type pin_item(int pin, bit level);
      sgic_pkg::req_type r;
      r = '0;
      r.func = sgic_pkg::FUNC_PIN;
      r.pin_number = pin[sgic_pkg::PIN_W-1:0];
      r.pin_level = level;
      return r;
   endfunction

   // Most traffic goes to a few pairs spread over the status words so that
   // edges and clears actually meet.
   function automatic int pick_pair();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom_range(0, sgic_pkg::PIN_PAIRS - 1);
      end
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return 31;
         3: return 32;
         4: return 100;
         5: return 159;
         6: return 224;
         default: return 255;
      endcase
   endfunction

   function automatic sgic_pkg::req_type random_item();
      sgic_pkg::req_type r;
      int                sel;
      r.func = FUNC_NONE;
      r.reg_addr = sgic_pkg::ADDR_W'($urandom);
      r.write_data = $urandom;
      r.pin_number = sgic_pkg::PIN_W'($urandom);
      r.pin_level = 1'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
         r.func = sgic_pkg::FUNC_READ;
         if ($urandom_range(0, 1) == 0) begin
            r.reg_addr = sgic_pkg::ADDR_W'(sgic_pkg::STATUS_BASE +
                                           $urandom_range(0, sgic_pkg::STATUS_WORDS - 1));
         end else if ($urandom_range(0, 3) != 0) begin
            r.reg_addr = sgic_pkg::ADDR_W'(sgic_pkg::CONTROL_BASE + pick_pair());
         end
      end else if (sel < 45) begin
         r.func = sgic_pkg::FUNC_WRITE;
         if ($urandom_range(0, 6) != 0) begin
            r.reg_addr = sgic_pkg::ADDR_W'(sgic_pkg::CONTROL_BASE + pick_pair());
         end
         if ($urandom_range(0, 4) != 0) begin
            r.write_data = $urandom_range(0, 127);
         end
      end else if (sel < 95) begin
         r.func = sgic_pkg::FUNC_PIN;
         r.pin_number = sgic_pkg::PIN_W'(pick_pair() * 2 + $urandom_range(0, 1));
      end
      return r;
   endfunction

   task automatic queue_item(sgic_pkg::req_type r, bit drain_first);
      stim_type e;
      e.req = r;
      e.drain_first = drain_first;
      items_to_send.push_back(e);
   endtask

   // Driver: record each accepted transfer in the model, then present the
   // next item, hold a stalled one, or idle for a short burst.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
         sent_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            responses_due.push_back(next_response(req_data));
            sent_count++;
         end
         idle_phase = (sent_count / 80) % 4;
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (idle_left > 0) begin
            idle_left--;
            req_valid <= 1'b0;
         end else if (items_to_send.size() == 0) begin
            req_valid <= 1'b0;
         end else if (items_to_send[0].drain_first && responses_due.size() != 0) begin
            req_valid <= 1'b0;
         end else if (items_to_send.size() > CALM_TAIL && idle_phase != 0 &&
                      $urandom_range(0, 2 * idle_phase + 1) == 0) begin
            idle_left = $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data <= items_to_send.pop_front().req;
         end
      end
   end

   // Monitor: check every accepted response against the oldest expectation
   // and stall the response channel in short bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         rsp_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (responses_due.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("Response with nothing expected: rd=%h irq=%b chg=%b pair=%0d",
                           rsp_data.read_data, rsp_data.irq_line, rsp_data.out_changed,
                           rsp_data.out_change_pair);
               end
            end else begin
               sgic_pkg::rsp_type want;
               want = responses_due.pop_front();
               if (want.read_data !== rsp_data.read_data ||
                   want.irq_line !== rsp_data.irq_line ||
                   want.out_changed !== rsp_data.out_changed ||
                   want.out_change_pair !== rsp_data.out_change_pair) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display({"Response %0d: expected rd=%h irq=%b chg=%b pair=%0d,",
                               " got rd=%h irq=%b chg=%b pair=%0d"},
                              rsp_seen, want.read_data, want.irq_line, want.out_changed,
                              want.out_change_pair, rsp_data.read_data, rsp_data.irq_line,
                              rsp_data.out_changed, rsp_data.out_change_pair);
                  end
               end
            end
            rsp_seen++;
         end
         hold_phase = (rsp_seen / 80 + 2) % 4;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_seen + CALM_TAIL < total_items && hold_phase != 0 &&
                      $urandom_range(0, 2 * hold_phase + 1) == 0) begin
            hold_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      errors = 0;
      set_bits = '0;
      foreach (ctl_words[i]) ctl_words[i] = '0;
      foreach (sts_words[i]) sts_words[i] = '0;

      // Directed part: rising edge and clear, all-ones word with dual edge,
      // ignored and unmapped accesses, each trigger type, repeats.
      queue_item(read_item(sgic_pkg::STATUS_BASE), 1'b0);
      queue_item(read_item(sgic_pkg::CONTROL_BASE + 255), 1'b0);
      queue_item(write_item(sgic_pkg::CONTROL_BASE,
                            ctl_word(1'b1, sgic_pkg::TRIG_RISE, 1'b0, 1'b0, 1'b0)), 1'b0);
      queue_item(pin_item(0, 1'b1), 1'b0);
      queue_item(read_item(sgic_pkg::STATUS_BASE), 1'b0);
      queue_item(write_item(sgic_pkg::CONTROL_BASE,
                            ctl_word(1'b1, sgic_pkg::TRIG_RISE, 1'b1, 1'b0, 1'b1)), 1'b0);
      queue_item(write_item(sgic_pkg::CONTROL_BASE + 255, 32'hFFFF_FFFF), 1'b0);
      queue_item(read_item(sgic_pkg::STATUS_BASE + sgic_pkg::STATUS_WORDS - 1), 1'b0);
      queue_item(read_item(sgic_pkg::CONTROL_BASE + 255), 1'b0);
      queue_item(write_item(sgic_pkg::STATUS_BASE + 3, 32'hFFFF_FFFF), 1'b0);
      queue_item(read_item(1023), 1'b0);
      queue_item(read_item(sgic_pkg::STATUS_BASE + sgic_pkg::STATUS_WORDS), 1'b0);
      queue_item(write_item(1023, 32'hFFFF_FFFF), 1'b0);
      queue_item('{func: FUNC_NONE, reg_addr: '1, write_data: '1, pin_number: '1,
                   pin_level: 1'b1}, 1'b0);
      queue_item(pin_item(511, 1'b0), 1'b0);
      queue_item(write_item(sgic_pkg::CONTROL_BASE + 5,
                            ctl_word(1'b1, sgic_pkg::TRIG_LOW, 1'b0, 1'b0, 1'b0)), 1'b0);
      queue_item(pin_item(10, 1'b1), 1'b0);
      queue_item(pin_item(10, 1'b0), 1'b0);
      queue_item(write_item(sgic_pkg::CONTROL_BASE + 6,
                            ctl_word(1'b1, sgic_pkg::TRIG_HIGH, 1'b0, 1'b0, 1'b0)), 1'b0);
      queue_item(pin_item(12, 1'b1), 1'b0);
      queue_item(pin_item(12, 1'b0), 1'b0);
      queue_item(pin_item(12, 1'b1), 1'b0);
      queue_item(write_item(sgic_pkg::CONTROL_BASE + 7,
                            ctl_word(1'b1, sgic_pkg::TRIG_FALL, 1'b1, 1'b0, 1'b0)), 1'b0);
      queue_item(pin_item(14, 1'b0), 1'b0);
      queue_item(pin_item(14, 1'b0), 1'b0);
      queue_item(write_item(sgic_pkg::CONTROL_BASE + 8,
                            ctl_word(1'b0, sgic_pkg::TRIG_RISE, 1'b0, 1'b1, 1'b0)), 1'b0);
      queue_item(pin_item(16, 1'b1), 1'b0);
      queue_item(write_item(sgic_pkg::CONTROL_BASE + 5,
                            ctl_word(1'b1, sgic_pkg::TRIG_LOW, 1'b0, 1'b0, 1'b0)), 1'b0);

      // Random part; the sender drains the block completely a few times,
      // never in the calm tail.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         queue_item(random_item(), i % 400 == 0 && i + CALM_TAIL < RANDOM_ITEMS);
      end
      total_items = items_to_send.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (items_to_send.size() != 0 || req_valid || responses_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (responses_due.size() != 0) begin
         errors++;
      end

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Timeout guard.
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ serial_gpio_interrupt_controller.f @@
+incdir+hdl
hdl/sgic_pkg.sv
hdl/sgic_eval.sv
hdl/serial_gpio_interrupt_controller.sv
bench/tb_serial_gpio_interrupt_controller.sv
